// ===== src/sfph_pkg.sv =====
// shared constants and types for the sensor frame parser
`timescale 1ns / 1ps
`default_nettype none

package sfph_pkg;

   localparam int PAYLOAD_BYTES = 16;
   localparam int NUM_CH        = 8;
   localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [7:0]  HDR_BYTE     = 8'h75;
   localparam logic [7:0]  TAIL_BYTE    = 8'h11;
   localparam logic [16:0] WHITE_GAP    = 17'd100;
   localparam logic [15:0] LEVEL_MAX    = 16'hFFFF;
   localparam logic [15:0] THRESH_RESET = 16'd700;

   typedef logic [PAYLOAD_BYTES-1:0][7:0] frame_type;

endpackage

`default_nettype wire

// ===== src/sfph_front.sv =====
// byte parser: header, payload collection and tail check
`timescale 1ns / 1ps
`default_nettype none

module sfph_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept_in,
   input  wire logic [7:0]        rx_byte,
   output sfph_pkg::frame_type    frame_out,
   output logic                   frame_push
);
   import sfph_pkg::*;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_COLLECT,
      PH_TAIL
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   frame_type         store_ff;

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      case (phase_ff)
         PH_WAIT: begin
            if (rx_byte == HDR_BYTE) begin
               phase_in = PH_COLLECT;
               idx_in   = '0;
            end
         end
         PH_COLLECT: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(PAYLOAD_BYTES - 1)) begin
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
            phase_in = PH_WAIT;
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

   assign frame_push = accept_in && (phase_ff == PH_TAIL) && (rx_byte == TAIL_BYTE);
   assign frame_out  = store_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         idx_ff   <= '0;
      end else if (accept_in) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         if (phase_ff == PH_COLLECT) begin
            store_ff[idx_ff] <= rx_byte;
         end
      end
   end

`ifndef SYNTHESIS
   a_tail_index_wrapped: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TAIL |-> idx_ff == '0)
      else $error("tail phase with nonzero payload index");

   a_push_after_tail: assert property (@(posedge clock) disable iff (reset)
      frame_push |=> phase_ff == PH_WAIT)
      else $error("frame push did not return parser to wait");
`endif

endmodule

`default_nettype wire

// ===== src/sfph_queue.sv =====
// short frame queue between parser and map update
`timescale 1ns / 1ps
`default_nettype none

module sfph_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sfph_pkg::frame_type push_data,
   output logic                   full,
   output logic                   valid,
   input  wire logic              pop,
   output sfph_pkg::frame_type    pop_data
);
   import sfph_pkg::*;

   frame_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff           <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("frame pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== src/sfph_back.sv =====
// hysteresis map update, threshold register and result register
`timescale 1ns / 1ps
`default_nettype none

module sfph_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [15:0]       csr_black_threshold,
   input  wire logic              frame_valid,
   input  wire sfph_pkg::frame_type frame_in,
   output logic                   frame_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [7:0]             line_map,
   output logic [sfph_pkg::NUM_CH-1:0][15:0] levels
);
   import sfph_pkg::*;

   logic [15:0]              thresh_ff;
   logic [7:0]               held_map_ff, map_in;
   logic                     out_valid_ff;
   logic [7:0]               out_map_ff;
   logic [NUM_CH-1:0][15:0]  out_level_ff, level_in;
   logic [16:0]              white_sum;
   logic [15:0]              white;
   logic                     load;

   assign csr_ready = 1'b1;
   assign white_sum = {1'b0, thresh_ff} + WHITE_GAP;
   assign white     = white_sum[16] ? LEVEL_MAX : white_sum[15:0];
   assign load      = frame_valid && (!out_valid_ff || rsp_pop);
   assign frame_pop = load;

   always_comb begin
      map_in = held_map_ff;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         level_in[ch] = {frame_in[2*ch], frame_in[2*ch+1]};
         if (level_in[ch] < thresh_ff) begin
            map_in[ch] = 1'b1;
         end else if (level_in[ch] > white) begin
            map_in[ch] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         held_map_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            thresh_ff <= csr_black_threshold;
         end
         if (load) begin
            held_map_ff  <= map_in;
            out_map_ff   <= map_in;
            out_level_ff <= level_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign line_map  = out_map_ff;
   assign levels    = out_level_ff;

`ifndef SYNTHESIS
   a_map_matches_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_map_ff == held_map_ff)
      else $error("result map differs from held map");

   a_held_only_on_load: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(held_map_ff))
      else $error("held map changed without a frame");
`endif

endmodule

`default_nettype wire

// ===== src/sensor_frame_parser_hysteresis_core.sv =====
// top level of the sensor frame parser with hysteresis black-line map
//
// channel   direction  handshake          payload
// req_      in         push / full        rx_byte (8)
// rsp_      out        empty / pop        line_map (8), level_ch0..7 (16 each)
// csr_      in         valid / ready      black_threshold (16)
//
// one byte is taken every cycle while full is low; full rises only while both
// queue entries and the result register hold frames that the result side has
// not taken; a good tail byte's frame is written into the queue and then into
// the result register when that register is free
// synchronous reset: parser waits for a header, map cleared, threshold 700
// csr writes are always taken and apply to the next frame updated
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_parser_hysteresis_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_line_map,
   output logic [15:0]      rsp_level_ch0,
   output logic [15:0]      rsp_level_ch1,
   output logic [15:0]      rsp_level_ch2,
   output logic [15:0]      rsp_level_ch3,
   output logic [15:0]      rsp_level_ch4,
   output logic [15:0]      rsp_level_ch5,
   output logic [15:0]      rsp_level_ch6,
   output logic [15:0]      rsp_level_ch7,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_black_threshold
);
   import sfph_pkg::*;

   frame_type                front_frame, queue_frame;
   logic                     front_push, queue_full, queue_valid, queue_pop;
   logic                     accept;
   logic [NUM_CH-1:0][15:0]  levels;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   sfph_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept_in  (accept),
      .rx_byte    (req_rx_byte),
      .frame_out  (front_frame),
      .frame_push (front_push)
   );

   sfph_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_frame),
      .full      (queue_full),
      .valid     (queue_valid),
      .pop       (queue_pop),
      .pop_data  (queue_frame)
   );

   sfph_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_black_threshold (csr_black_threshold),
      .frame_valid         (queue_valid),
      .frame_in            (queue_frame),
      .frame_pop           (queue_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .line_map            (rsp_line_map),
      .levels              (levels)
   );

   assign rsp_level_ch0 = levels[0];
   assign rsp_level_ch1 = levels[1];
   assign rsp_level_ch2 = levels[2];
   assign rsp_level_ch3 = levels[3];
   assign rsp_level_ch4 = levels[4];
   assign rsp_level_ch5 = levels[5];
   assign rsp_level_ch6 = levels[6];
   assign rsp_level_ch7 = levels[7];

endmodule

`default_nettype wire
